>>> sv/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants of the position PID motor drive: field widths,
// configuration register codes, reset values and the records that travel
// between the pipeline stages.
// ----------------------------------------------------------------------------
package pmd_pkg;

  localparam int unsigned COUNT_W        = 16;
  localparam int unsigned POS_W          = 32;
  localparam int unsigned GAIN_W         = 24;
  localparam int unsigned COEF_W         = GAIN_W + 2;
  localparam int unsigned PROD_W         = COEF_W + 1 + POS_W;
  localparam int unsigned INC_W          = PROD_W + 1;
  localparam int unsigned ACC_W          = 64;
  localparam int unsigned GAIN_FRAC_BITS = 16;
  localparam int unsigned DRIVE_W        = ACC_W - GAIN_FRAC_BITS;
  localparam int unsigned DUTY_W         = 16;
  localparam int unsigned BAND_W         = 16;
  localparam int unsigned CFG_INDEX_W    = 3;
  localparam int unsigned CFG_DATA_W     = GAIN_W;

  localparam logic [COUNT_W-1:0] LAST_COUNT_RESET = COUNT_W'(30000);
  localparam logic [GAIN_W-1:0]  KP_RESET         = GAIN_W'(131072);
  localparam logic [GAIN_W-1:0]  KI_RESET         = GAIN_W'(66);
  localparam logic [GAIN_W-1:0]  KD_RESET         = GAIN_W'(458752);
  localparam logic [BAND_W-1:0]  DEADBAND_RESET   = BAND_W'(2);
  localparam logic [DUTY_W-1:0]  PWM_LIMIT_RESET  = DUTY_W'(65535);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_KP_GAIN        = 3'd0,
    CFG_KI_GAIN        = 3'd1,
    CFG_KD_GAIN        = 3'd2,
    CFG_LOOP_ENABLED   = 3'd3,
    CFG_ERROR_DEADBAND = 3'd4,
    CFG_PWM_LIMIT      = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_TICK       = 1'b0,
    OP_SET_TARGET = 1'b1
  } op_e;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic              loop_enabled;
    logic [BAND_W-1:0] error_deadband;
    logic [DUTY_W-1:0] pwm_limit;
  } cfg_t;

  // Error stage record: error of this tick and the history it is combined with.
  typedef struct packed {
    op_e                     op;
    logic                    active;
    logic signed [POS_W-1:0] err;
    logic signed [POS_W-1:0] e1;
    logic signed [POS_W-1:0] e2;
    logic [POS_W-1:0]        pos;
  } err_item_t;

  // Accumulator stage record: updated PID accumulator.
  typedef struct packed {
    op_e                     op;
    logic                    active;
    logic signed [ACC_W-1:0] acc;
    logic [POS_W-1:0]        pos;
  } acc_item_t;

endpackage

>>> sv/pmd_track.sv
// ----------------------------------------------------------------------------
// pmd_track
// Input register, encoder position tracking and error stage. Keeps the
// counter, position, setpoint and error history state.
// ----------------------------------------------------------------------------
module pmd_track (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pmd_pkg::cfg_t                      cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [pmd_pkg::COUNT_W-1:0]        encoder_count_i,
  input  logic signed [pmd_pkg::POS_W-1:0]   target_position_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output pmd_pkg::err_item_t                 out_o
);

  typedef struct packed {
    pmd_pkg::op_e                      op;
    logic [pmd_pkg::COUNT_W-1:0]       count;
    logic [pmd_pkg::POS_W-1:0]         target;
  } in_item_t;

  typedef struct packed {
    pmd_pkg::op_e                      op;
    logic [pmd_pkg::POS_W-1:0]         pos;
    logic [pmd_pkg::POS_W-1:0]         setp;
  } pos_item_t;

  logic                 s0_valid_q, s1_valid_q, s2_valid_q;
  in_item_t             s0_q;
  pos_item_t            s1_q;
  pmd_pkg::err_item_t   s2_q;
  logic                 ready0, ready1, ready2;
  logic                 load1, load2;

  logic [pmd_pkg::COUNT_W-1:0]      last_count_q;
  logic [pmd_pkg::POS_W-1:0]        position_q, setpoint_q;
  logic signed [pmd_pkg::POS_W-1:0] e1_q, e2_q;

  logic [pmd_pkg::COUNT_W-1:0]      count_delta;
  logic [pmd_pkg::POS_W-1:0]        position_d;
  logic [pmd_pkg::POS_W:0]          err_wide;
  logic signed [pmd_pkg::POS_W-1:0] err_sat;
  logic [pmd_pkg::POS_W-1:0]        err_mag;
  logic                             active;
  logic                             is_set;

  assign ready2 = !s2_valid_q || out_ready_i;
  assign ready1 = !s1_valid_q || ready2;
  assign ready0 = !s0_valid_q || ready1;
  assign load1  = s0_valid_q && ready1;
  assign load2  = s1_valid_q && ready2;

  assign in_ready_o  = ready0;
  assign out_valid_o = s2_valid_q;
  assign out_o       = s2_q;

  // The counter delta wraps modulo the counter width and is read as signed.
  assign count_delta = s0_q.count - last_count_q;
  assign position_d  = position_q
                     + {{(pmd_pkg::POS_W-pmd_pkg::COUNT_W){count_delta[pmd_pkg::COUNT_W-1]}},
                        count_delta};

  assign is_set   = (s1_q.op == pmd_pkg::OP_SET_TARGET);
  assign err_wide = {s1_q.setp[pmd_pkg::POS_W-1], s1_q.setp}
                  - {s1_q.pos[pmd_pkg::POS_W-1], s1_q.pos};

  always_comb begin
    if (err_wide[pmd_pkg::POS_W] != err_wide[pmd_pkg::POS_W-1]) begin
      err_sat = err_wide[pmd_pkg::POS_W] ? {1'b1, {(pmd_pkg::POS_W-1){1'b0}}}
                                         : {1'b0, {(pmd_pkg::POS_W-1){1'b1}}};
    end else begin
      err_sat = err_wide[pmd_pkg::POS_W-1:0];
    end
    err_mag = err_sat[pmd_pkg::POS_W-1] ? (~err_sat + 1'b1) : err_sat;
    active  = !is_set && cfg_i.loop_enabled
           && (err_mag >= {{(pmd_pkg::POS_W-pmd_pkg::BAND_W){1'b0}}, cfg_i.error_deadband});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (ready0) s0_valid_q <= in_valid_i;
      if (ready1) s1_valid_q <= s0_valid_q;
      if (ready2) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= pmd_pkg::LAST_COUNT_RESET;
      position_q   <= '0;
      setpoint_q   <= '0;
      e1_q         <= '0;
      e2_q         <= '0;
    end else begin
      if (load1) begin
        if (s0_q.op == pmd_pkg::OP_SET_TARGET) begin
          setpoint_q <= s0_q.target;
        end else begin
          position_q   <= position_d;
          last_count_q <= s0_q.count;
        end
      end
      if (load2) begin
        if (is_set) begin
          e1_q <= '0;
          e2_q <= '0;
        end else if (active) begin
          e2_q <= e1_q;
          e1_q <= err_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready0 && in_valid_i) begin
      s0_q.op     <= pmd_pkg::op_e'(operation_i);
      s0_q.count  <= encoder_count_i;
      s0_q.target <= target_position_i;
    end
    if (load1) begin
      s1_q.op <= s0_q.op;
      if (s0_q.op == pmd_pkg::OP_SET_TARGET) begin
        s1_q.pos  <= position_q;
        s1_q.setp <= s0_q.target;
      end else begin
        s1_q.pos  <= position_d;
        s1_q.setp <= setpoint_q;
      end
    end
    if (load2) begin
      s2_q.op     <= s1_q.op;
      s2_q.active <= active;
      s2_q.err    <= err_sat;
      s2_q.e1     <= e1_q;
      s2_q.e2     <= e2_q;
      s2_q.pos    <= s1_q.pos;
    end
  end

  a_history_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load2 && is_set |=> (e1_q == '0) && (e2_q == '0))
    else $error("error history not cleared by a new target");

  a_history_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load2 |=> $stable(e1_q) && $stable(e2_q))
    else $error("error history changed without an item");

endmodule

>>> sv/pmd_pid.sv
// ----------------------------------------------------------------------------
// pmd_pid
// Incremental PID datapath: product stage, increment sum stage and the
// saturating accumulator stage.
// ----------------------------------------------------------------------------
module pmd_pid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pmd_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pmd_pkg::err_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pmd_pkg::acc_item_t  out_o
);

  typedef struct packed {
    pmd_pkg::op_e                       op;
    logic                               active;
    logic [pmd_pkg::POS_W-1:0]          pos;
    logic signed [pmd_pkg::PROD_W-1:0]  p0;
    logic signed [pmd_pkg::PROD_W-1:0]  m1;
    logic signed [pmd_pkg::PROD_W-1:0]  p2;
  } prod_item_t;

  typedef struct packed {
    pmd_pkg::op_e                       op;
    logic                               active;
    logic [pmd_pkg::POS_W-1:0]          pos;
    logic signed [pmd_pkg::INC_W-1:0]   inc;
  } inc_item_t;

  logic                s3_valid_q, s4_valid_q, s5_valid_q;
  prod_item_t          s3_q;
  inc_item_t           s4_q;
  pmd_pkg::acc_item_t  s5_q;
  logic                ready3, ready4, ready5;
  logic                load3, load4, load5;

  logic signed [pmd_pkg::ACC_W-1:0]    acc_q;
  logic [pmd_pkg::COEF_W-1:0]          coef0, coef1;
  logic signed [pmd_pkg::COEF_W:0]     coef0_s, coef1_s, coef2_s;
  logic signed [pmd_pkg::PROD_W-1:0]   p0, m1, p2;
  logic signed [pmd_pkg::INC_W-1:0]    inc;
  logic [pmd_pkg::ACC_W:0]             acc_sum;
  logic signed [pmd_pkg::ACC_W-1:0]    acc_sat;
  logic                                s5_is_set;

  assign ready5 = !s5_valid_q || out_ready_i;
  assign ready4 = !s4_valid_q || ready5;
  assign ready3 = !s3_valid_q || ready4;
  assign load3  = in_valid_i && ready3;
  assign load4  = s3_valid_q && ready4;
  assign load5  = s4_valid_q && ready5;

  assign in_ready_o  = ready3;
  assign out_valid_o = s5_valid_q;
  assign out_o       = s5_q;

  // A0 = kp + ki + kd, A1 = -(kp + 2*kd), A2 = kd; A1 is applied as a subtract.
  assign coef0   = {2'b00, cfg_i.kp_gain} + {2'b00, cfg_i.ki_gain} + {2'b00, cfg_i.kd_gain};
  assign coef1   = {2'b00, cfg_i.kp_gain} + {1'b0, cfg_i.kd_gain, 1'b0};
  assign coef0_s = $signed({1'b0, coef0});
  assign coef1_s = $signed({1'b0, coef1});
  assign coef2_s = $signed({3'b000, cfg_i.kd_gain});

  assign p0 = coef0_s * in_i.err;
  assign m1 = coef1_s * in_i.e1;
  assign p2 = coef2_s * in_i.e2;

  assign inc = {s3_q.p0[pmd_pkg::PROD_W-1], s3_q.p0}
             - {s3_q.m1[pmd_pkg::PROD_W-1], s3_q.m1}
             + {s3_q.p2[pmd_pkg::PROD_W-1], s3_q.p2};

  // Saturating add: an overflow shows as a mismatch of the two top sum bits.
  assign acc_sum = {acc_q[pmd_pkg::ACC_W-1], acc_q}
                 + {{(pmd_pkg::ACC_W+1-pmd_pkg::INC_W){s4_q.inc[pmd_pkg::INC_W-1]}}, s4_q.inc};

  always_comb begin
    if (acc_sum[pmd_pkg::ACC_W] != acc_sum[pmd_pkg::ACC_W-1]) begin
      acc_sat = acc_sum[pmd_pkg::ACC_W] ? {1'b1, {(pmd_pkg::ACC_W-1){1'b0}}}
                                        : {1'b0, {(pmd_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[pmd_pkg::ACC_W-1:0];
    end
  end

  assign s5_is_set = (s4_q.op == pmd_pkg::OP_SET_TARGET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      if (ready3) s3_valid_q <= in_valid_i;
      if (ready4) s4_valid_q <= s3_valid_q;
      if (ready5) s5_valid_q <= s4_valid_q;
      if (load5) begin
        if (s5_is_set) begin
          acc_q <= '0;
        end else if (s4_q.active) begin
          acc_q <= acc_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load3) begin
      s3_q.op     <= in_i.op;
      s3_q.active <= in_i.active;
      s3_q.pos    <= in_i.pos;
      s3_q.p0     <= p0;
      s3_q.m1     <= m1;
      s3_q.p2     <= p2;
    end
    if (load4) begin
      s4_q.op     <= s3_q.op;
      s4_q.active <= s3_q.active;
      s4_q.pos    <= s3_q.pos;
      s4_q.inc    <= inc;
    end
    if (load5) begin
      s5_q.op     <= s4_q.op;
      s5_q.active <= s4_q.active;
      s5_q.pos    <= s4_q.pos;
      s5_q.acc    <= s5_is_set ? '0 : (s4_q.active ? acc_sat : acc_q);
    end
  end

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load5 && s5_is_set |=> acc_q == '0)
    else $error("accumulator not cleared by a new target");

  a_acc_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load5 && !s5_is_set && !s4_q.active |=> $stable(acc_q))
    else $error("accumulator changed on an inactive tick");

endmodule

>>> sv/pmd_drive.sv
// ----------------------------------------------------------------------------
// pmd_drive
// Output stage: truncates the accumulator to an integer drive, limits its
// magnitude, sets the direction pins and holds the result for the receiver.
// ----------------------------------------------------------------------------
module pmd_drive (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pmd_pkg::cfg_t                      cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  pmd_pkg::acc_item_t                 in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pmd_pkg::DUTY_W-1:0]         pwm_duty_o,
  output logic                               dir_forward_o,
  output logic                               dir_reverse_o,
  output logic signed [pmd_pkg::POS_W-1:0]   position_now_o
);

  logic                              out_valid_q;
  logic [pmd_pkg::DUTY_W-1:0]        duty_q;
  logic                              fwd_q, rev_q;
  logic [pmd_pkg::POS_W-1:0]         pos_q;
  logic                              ready6;

  logic [pmd_pkg::ACC_W-1:0]         acc_mag;
  logic [pmd_pkg::DRIVE_W-1:0]       drive_mag;
  logic                              drive_nz, acc_neg;
  logic [pmd_pkg::DUTY_W-1:0]        duty_d;

  assign ready6     = !out_valid_q || !out_stall_i;
  assign in_ready_o = ready6;

  // Truncation toward zero: the magnitude is |acc| shifted down.
  assign acc_neg   = in_i.acc[pmd_pkg::ACC_W-1];
  assign acc_mag   = acc_neg ? (~in_i.acc + 1'b1) : in_i.acc;
  assign drive_mag = acc_mag[pmd_pkg::ACC_W-1:pmd_pkg::GAIN_FRAC_BITS];
  assign drive_nz  = |drive_mag;

  always_comb begin
    if (!in_i.active) begin
      duty_d = '0;
    end else if (drive_mag > {{(pmd_pkg::DRIVE_W-pmd_pkg::DUTY_W){1'b0}}, cfg_i.pwm_limit}) begin
      duty_d = cfg_i.pwm_limit;
    end else begin
      duty_d = drive_mag[pmd_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready6) begin
      out_valid_q <= in_valid_i && (in_i.op == pmd_pkg::OP_TICK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready6 && in_valid_i) begin
      duty_q <= duty_d;
      fwd_q  <= in_i.active && !acc_neg && drive_nz;
      rev_q  <= in_i.active && acc_neg && drive_nz;
      pos_q  <= in_i.pos;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pwm_duty_o     = duty_q;
  assign dir_forward_o  = fwd_q;
  assign dir_reverse_o  = rev_q;
  assign position_now_o = pos_q;

  a_duty_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pwm_duty_o <= cfg_i.pwm_limit)
    else $error("drive magnitude above the limit");

  a_duty_has_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (pwm_duty_o != '0) |-> $onehot({dir_forward_o, dir_reverse_o}))
    else $error("nonzero drive without exactly one direction");

endmodule

>>> sv/position_pid_motor_drive.sv
// ----------------------------------------------------------------------------
// position_pid_motor_drive
// Position controller for one motor with a quadrature encoder: position
// tracking, incremental PID with deadband and enable, and a limited drive.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle and keeps going as long as the
// result side keeps up. Each word is either a control tick, which carries the
// 16-bit encoder counter reading, or a new target, which sets the setpoint and
// clears the PID history and accumulator. A tick yields one result word once it
// has passed every stage: the drive magnitude, two direction pins and the
// updated position. A new target yields no result word. The pipeline has
// seven register stages (input, position, error, products, increment sum,
// accumulator, output) and every stage holds when the stage after it is full,
// so words that are already in flight fill the empty stages while the output
// word waits to be taken. Position and accumulator update as their item enters
// the next stage, so ticks can run back to back. Configuration must be written
// through the plain write port while no word is in flight; the block does not
// enforce this. Writes to an index past the last register are ignored.
// ----------------------------------------------------------------------------
module position_pid_motor_drive (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port.
  input  logic                                  cfg_write_i,
  input  logic [pmd_pkg::CFG_INDEX_W-1:0]       cfg_index_i,
  input  logic [pmd_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // Input words.
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  operation_i,
  input  logic [pmd_pkg::COUNT_W-1:0]           encoder_count_i,
  input  logic signed [pmd_pkg::POS_W-1:0]      target_position_i,
  // Result words.
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [pmd_pkg::DUTY_W-1:0]            pwm_duty_o,
  output logic                                  dir_forward_o,
  output logic                                  dir_reverse_o,
  output logic signed [pmd_pkg::POS_W-1:0]      position_now_o
);

  pmd_pkg::cfg_t       cfg_q;
  logic                trk_ready, trk_valid;
  pmd_pkg::err_item_t  trk_item;
  logic                pid_ready, pid_valid;
  pmd_pkg::acc_item_t  pid_item;
  logic                drv_ready;

  // Configuration registers. Each write keeps only the bits of its register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain        <= pmd_pkg::KP_RESET;
      cfg_q.ki_gain        <= pmd_pkg::KI_RESET;
      cfg_q.kd_gain        <= pmd_pkg::KD_RESET;
      cfg_q.loop_enabled   <= 1'b0;
      cfg_q.error_deadband <= pmd_pkg::DEADBAND_RESET;
      cfg_q.pwm_limit      <= pmd_pkg::PWM_LIMIT_RESET;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        pmd_pkg::CFG_KP_GAIN:        cfg_q.kp_gain        <= cfg_data_i;
        pmd_pkg::CFG_KI_GAIN:        cfg_q.ki_gain        <= cfg_data_i;
        pmd_pkg::CFG_KD_GAIN:        cfg_q.kd_gain        <= cfg_data_i;
        pmd_pkg::CFG_LOOP_ENABLED:   cfg_q.loop_enabled   <= cfg_data_i[0];
        pmd_pkg::CFG_ERROR_DEADBAND: cfg_q.error_deadband <= cfg_data_i[pmd_pkg::BAND_W-1:0];
        pmd_pkg::CFG_PWM_LIMIT:      cfg_q.pwm_limit      <= cfg_data_i[pmd_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register, position tracking and error with its history.
  pmd_track u_track (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (trk_ready),
    .operation_i       (operation_i),
    .encoder_count_i   (encoder_count_i),
    .target_position_i (target_position_i),
    .out_valid_o       (trk_valid),
    .out_ready_i       (pid_ready),
    .out_o             (trk_item)
  );

  // Products, increment and saturating accumulator.
  pmd_pid u_pid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (trk_valid),
    .in_ready_o  (pid_ready),
    .in_i        (trk_item),
    .out_valid_o (pid_valid),
    .out_ready_i (drv_ready),
    .out_o       (pid_item)
  );

  // Drive truncation, limiting and the output register.
  pmd_drive u_drive (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (pid_valid),
    .in_ready_o     (drv_ready),
    .in_i           (pid_item),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pwm_duty_o     (pwm_duty_o),
    .dir_forward_o  (dir_forward_o),
    .dir_reverse_o  (dir_reverse_o),
    .position_now_o (position_now_o)
  );

  assign in_stall_o = !trk_ready;

endmodule
